### hw/rtl/m4inv_pkg.sv
// Shared types, widths and constant tables for the 4x4 matrix inverse block.
// No dependencies; the lane, merging stage, top level and testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package m4inv_pkg;

	// Default fraction width of the Q-format elements.
	localparam int FRAC_BITS_DEF = 16;

	// One matrix row as stored: four 32-bit elements, column 0 in the low bits.
	localparam int ELEM_W = 32;
	localparam int ROW_W  = 4 * ELEM_W;
	localparam int ROWS   = 4;

	// Exact widths: a cofactor is below 2^96, the determinant below 2^129.
	localparam int COF_W = 97;
	localparam int DET_W = 130;

	// Row number that closes a matrix and starts the inversion.
	localparam logic [1:0] LAST_ROW = 2'd3;

	// The six permutations of a 3x3 determinant and their parity.
	localparam logic [1:0] PERM0 [6] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd1};
	localparam logic [1:0] PERM1 [6] = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd1, 2'd0};
	localparam logic [1:0] PERM2 [6] = '{2'd2, 2'd0, 2'd1, 2'd1, 2'd0, 2'd2};
	localparam logic       PERM_NEG [6] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};

	// Control from the top level to each lane.
	typedef struct packed {
		logic start;
		logic div_go;
	} lane_ctl_t;

	// Status from each lane to the top level.
	typedef struct packed {
		logic cof_done;
		logic div_done;
	} lane_st_t;

	// Determinant as sign and magnitude, with a zero flag.
	typedef struct packed {
		logic [DET_W-1:0] mag;
		logic             neg;
		logic             zero;
	} det_t;

endpackage

`default_nettype wire

### hw/rtl/m4inv_ram.sv
// Generic RAM with one write port and two registered read ports.
// Depends on nothing; used for the row store of every lane.
`timescale 1ns / 1ps
`default_nettype none

module m4inv_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr0,
	input  wire logic [$clog2(DEPTH)-1:0] raddr1,
	output logic      [WIDTH-1:0]         rdata0,
	output logic      [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

`default_nettype wire

### hw/rtl/m4inv_lane.sv
// One lane: computes the four cofactors of one matrix column, its share of
// the determinant, and one row of the inverse. Uses m4inv_pkg and m4inv_ram.
`timescale 1ns / 1ps
`default_nettype none

module m4inv_lane import m4inv_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [1:0]              col,
	input  wire logic                    wr_en,
	input  wire logic [1:0]              wr_row,
	input  wire logic [ROW_W-1:0]        wr_data,
	input  wire lane_ctl_t               ctl,
	input  wire det_t                    det,
	output lane_st_t                     st,
	output logic signed [DET_W-1:0]      contrib,
	output logic signed [ELEM_W-1:0]     inv [4]
);

	localparam int NUM_W = COF_W + 2 * FRAC_BITS + 2;
	localparam int DEN_W = DET_W + 34;
	localparam int DIV_W = (NUM_W > DEN_W) ? NUM_W : DEN_W;

	typedef enum logic [2:0] {L_IDLE, L_COF, L_DET, L_WAIT, L_DIV, L_HOLD} lst_t;

	lst_t                    state_q;
	logic [1:0]              r_q;
	logic [2:0]              t_q;
	logic [2:0]              s_q;
	logic [1:0]              idx_q;
	logic [5:0]              dc_q;

	logic signed [65:0]      prod_q;
	logic [63:0]             p_q;
	logic [ELEM_W-1:0]       c_q;
	logic signed [COF_W-1:0] acc_q;
	logic signed [COF_W-1:0] cof_q [4];
	logic signed [DET_W-1:0] e_q;
	logic [DIV_W-1:0]        rem_q;
	logic [DIV_W-1:0]        dsh_q;
	logic [32:0]             q_q;
	logic                    qneg_q;
	logic signed [ELEM_W-1:0] inv_q [4];

	logic [1:0]              raddr0;
	logic [ROW_W-1:0]        rd0;
	logic [ROW_W-1:0]        rd1;
	logic [1:0]              rs0, rs1, rs2, ca, cb, cc;
	logic [ELEM_W-1:0]       el_a, el_b, el_c;
	logic signed [32:0]      mul_a, mul_b;
	logic signed [65:0]      mul;
	logic                    term_neg;
	logic signed [COF_W-1:0] lo_ext, delta, acc_nx;
	logic signed [DET_W-1:0] e_ext;
	logic signed [COF_W-1:0] cof_sel;
	logic [COF_W-1:0]        nmag;
	logic [DIV_W-1:0]        num_init, den_init, diff;
	logic                    ge;
	logic [ELEM_W-1:0]       res;

	function automatic logic [1:0] skip_idx(input logic [1:0] k, input logic [1:0] x);
		return (k < x) ? k : 2'(k + 2'd1);
	endfunction

	// Row store copy of this lane.
	m4inv_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_ram (
		.clk    (clk),
		.we     (wr_en),
		.waddr  (wr_row),
		.wdata  (wr_data),
		.raddr0 (raddr0),
		.raddr1 (rs1),
		.rdata0 (rd0),
		.rdata1 (rd1)
	);

	// Rows and columns of the 3x3 submatrix and of the current term.
	always_comb begin
		rs0 = skip_idx(2'd0, r_q);
		rs1 = skip_idx(2'd1, r_q);
		rs2 = skip_idx(2'd2, r_q);
		ca  = skip_idx(PERM0[t_q], col);
		cb  = skip_idx(PERM1[t_q], col);
		cc  = skip_idx(PERM2[t_q], col);
		if (state_q == L_COF) begin
			raddr0 = (s_q == 3'd0) ? rs0 : rs2;
		end else begin
			raddr0 = 2'd0;
		end
		el_a = rd0[{ca, 5'b0} +: ELEM_W];
		el_b = rd1[{cb, 5'b0} +: ELEM_W];
		el_c = rd0[{cc, 5'b0} +: ELEM_W];
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			L_COF: begin
				case (s_q)
					3'd1: begin
						mul_a = {el_a[ELEM_W-1], el_a};
						mul_b = {el_b[ELEM_W-1], el_b};
					end
					3'd2: begin
						mul_a = {1'b0, prod_q[31:0]};
						mul_b = {el_c[ELEM_W-1], el_c};
					end
					3'd3: begin
						mul_a = {p_q[63], p_q[63:32]};
						mul_b = {c_q[ELEM_W-1], c_q};
					end
					default: ;
				endcase
			end
			L_DET: begin
				mul_a = {rd0[{col, 5'b0} + 31], rd0[{col, 5'b0} +: ELEM_W]};
				case (s_q)
					3'd1: mul_b = {1'b0, cof_q[0][31:0]};
					3'd2: mul_b = {1'b0, cof_q[0][63:32]};
					3'd3: mul_b = cof_q[0][96:64];
					default: mul_b = '0;
				endcase
			end
			default: ;
		endcase
		mul = mul_a * mul_b;
	end

	// Cofactor accumulation with the term sign and the checkerboard sign.
	always_comb begin
		term_neg = PERM_NEG[t_q] ^ r_q[0] ^ col[0];
		lo_ext   = COF_W'(prod_q);
		case (s_q)
			3'd3:    delta = lo_ext;
			3'd4:    delta = lo_ext <<< 32;
			default: delta = '0;
		endcase
		acc_nx = term_neg ? (acc_q - delta) : (acc_q + delta);
		case (s_q)
			3'd2:    e_ext = DET_W'(prod_q);
			3'd3:    e_ext = DET_W'(prod_q) <<< 32;
			3'd4:    e_ext = DET_W'(prod_q) <<< 64;
			default: e_ext = '0;
		endcase
	end

	// Restoring divider: rounded quotient of cofactor times 2^(2F) by the determinant.
	always_comb begin
		cof_sel  = cof_q[idx_q];
		nmag     = cof_sel[COF_W-1] ? COF_W'(-cof_sel) : COF_W'(cof_sel);
		num_init = (DIV_W'(nmag) << (2 * FRAC_BITS + 1)) + DIV_W'(det.mag);
		den_init = DIV_W'(det.mag) << 33;
		ge       = rem_q >= dsh_q;
		diff     = rem_q - dsh_q;
		if (q_q[32] || q_q[31]) begin
			res = qneg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			res = qneg_q ? 32'(-q_q[31:0]) : q_q[31:0];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			r_q     <= '0;
			t_q     <= '0;
			s_q     <= '0;
			idx_q   <= '0;
			dc_q    <= '0;
		end else begin
			case (state_q)
				L_IDLE, L_HOLD: begin
					if (ctl.start) begin
						state_q <= L_COF;
						r_q     <= '0;
						t_q     <= '0;
						s_q     <= '0;
					end
				end
				L_COF: begin
					if (s_q == 3'd4) begin
						s_q <= '0;
						if (t_q == 3'd5) begin
							t_q <= '0;
							if (r_q == 2'd3) begin
								state_q <= L_DET;
							end else begin
								r_q <= r_q + 2'd1;
							end
						end else begin
							t_q <= t_q + 3'd1;
						end
					end else begin
						s_q <= s_q + 3'd1;
					end
				end
				L_DET: begin
					if (s_q == 3'd4) begin
						s_q     <= '0;
						state_q <= L_WAIT;
					end else begin
						s_q <= s_q + 3'd1;
					end
				end
				L_WAIT: begin
					if (ctl.div_go) begin
						state_q <= L_DIV;
						idx_q   <= '0;
						dc_q    <= '0;
					end
				end
				L_DIV: begin
					if (dc_q == 6'd34) begin
						dc_q <= '0;
						if (idx_q == 2'd3) begin
							state_q <= L_HOLD;
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end else begin
						dc_q <= dc_q + 6'd1;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul;
		case (state_q)
			L_IDLE, L_HOLD: begin
				if (ctl.start) begin
					acc_q <= '0;
				end
			end
			L_COF: begin
				if (s_q == 3'd2) begin
					p_q <= prod_q[63:0];
					c_q <= el_c;
				end else if (s_q == 3'd3) begin
					acc_q <= acc_nx;
				end else if (s_q == 3'd4) begin
					if (t_q == 3'd5) begin
						cof_q[r_q] <= acc_nx;
						acc_q      <= '0;
					end else begin
						acc_q <= acc_nx;
					end
				end
			end
			L_DET: begin
				if (s_q == 3'd0) begin
					e_q <= '0;
				end else if (s_q >= 3'd2) begin
					e_q <= e_q + e_ext;
				end
			end
			L_DIV: begin
				if (dc_q == 6'd0) begin
					rem_q  <= num_init;
					dsh_q  <= den_init;
					q_q    <= '0;
					qneg_q <= cof_sel[COF_W-1] ^ det.neg;
				end else if (dc_q == 6'd34) begin
					inv_q[idx_q] <= res;
				end else begin
					if (ge) begin
						rem_q <= diff;
					end
					q_q   <= {q_q[31:0], ge};
					dsh_q <= dsh_q >> 1;
				end
			end
			default: ;
		endcase
	end

	assign st.cof_done = (state_q == L_WAIT);
	assign st.div_done = (state_q == L_HOLD);
	assign contrib     = e_q;
	assign inv         = inv_q;

endmodule

`default_nettype wire

### hw/rtl/m4inv_merge.sv
// Merging stage: adds the four lane shares of the determinant in a registered
// tree and returns sign, magnitude and zero flag. Uses m4inv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module m4inv_merge import m4inv_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  wire logic signed [DET_W-1:0] e [4],
	output det_t                    det,
	output logic                    valid
);

	logic signed [DET_W-1:0] s01_s1, s23_s1, sum_s2;
	logic                    v_s1, v_s2, v_s3;
	det_t                    det_s3;

	// Valid pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= go;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Adder tree and sign-magnitude conversion.
	always_ff @(posedge clk) begin
		s01_s1      <= e[0] + e[1];
		s23_s1      <= e[2] + e[3];
		sum_s2      <= s01_s1 + s23_s1;
		det_s3.neg  <= sum_s2[DET_W-1];
		det_s3.zero <= (sum_s2 == '0);
		det_s3.mag  <= sum_s2[DET_W-1] ? DET_W'(-sum_s2) : DET_W'(sum_s2);
	end

	assign det   = det_s3;
	assign valid = v_s3;

endmodule

`default_nettype wire

### hw/rtl/matrix4x4_inverse_top.sv
// Top level of the 4x4 fixed-point matrix inverse: four lanes, the merging
// stage and the output sequencing. Uses m4inv_pkg, m4inv_lane, m4inv_merge.
`timescale 1ns / 1ps
`default_nettype none

// The block takes a matrix of signed Q16.16 elements one row per request and
// returns the exact-rounded, saturated inverse as four row results, the last
// one flagged; a zero determinant gives zero rows with singular set. Rows 0 to
// 2 are stored in the lane row stores. A request for row 3 starts the
// inversion: each of the four lanes runs its cofactor products through its
// single 33x33 multiplier and then forms its determinant share, the merging
// stage adds the shares, and each lane then runs its bit-per-cycle divider
// for its four quotients, with handshakes between the control and the lanes.
// While results are waiting, rows 0 to 2 of the next matrix may already be
// sent; row 3 is held off until the last result row has been taken.

module matrix4x4_inverse_top import m4inv_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         row_number,
	input  wire logic signed [31:0] elem_col0,
	input  wire logic signed [31:0] elem_col1,
	input  wire logic signed [31:0] elem_col2,
	input  wire logic signed [31:0] elem_col3,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              out_row,
	output logic signed [31:0]      inv_col0,
	output logic signed [31:0]      inv_col1,
	output logic signed [31:0]      inv_col2,
	output logic signed [31:0]      inv_col3,
	output logic                    singular,
	output logic                    last_row
);

	typedef enum logic [2:0] {T_IDLE, T_COMP, T_MERGE, T_DIV, T_OUT} tst_t;

	tst_t                    st_q;
	logic                    start_q, merge_go_q, div_go_q, out_valid_q;
	logic [1:0]              out_row_q;
	det_t                    det_q;
	det_t                    det_m;
	logic                    det_v;
	lane_ctl_t               ctl;
	lane_st_t                lane_st [4];
	logic signed [DET_W-1:0] contrib [4];
	logic signed [31:0]      lane_inv [4][4];
	logic                    in_acc, all_cof, all_div;
	logic [ROW_W-1:0]        wr_data;

	assign in_ready = (st_q == T_IDLE) || ((st_q == T_OUT) && (row_number != LAST_ROW));
	assign in_acc   = in_valid && in_ready;
	assign wr_data  = {elem_col3, elem_col2, elem_col1, elem_col0};
	assign ctl      = '{start: start_q, div_go: div_go_q};

	// Lanes, one per matrix column.
	for (genvar g = 0; g < 4; g++) begin : g_lane
		m4inv_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.col     (2'(g)),
			.wr_en   (in_acc),
			.wr_row  (row_number),
			.wr_data (wr_data),
			.ctl     (ctl),
			.det     (det_q),
			.st      (lane_st[g]),
			.contrib (contrib[g]),
			.inv     (lane_inv[g])
		);
	end

	// Determinant from the lane shares.
	m4inv_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (merge_go_q),
		.e      (contrib),
		.det    (det_m),
		.valid  (det_v)
	);

	assign all_cof = lane_st[0].cof_done && lane_st[1].cof_done &&
	                 lane_st[2].cof_done && lane_st[3].cof_done;
	assign all_div = lane_st[0].div_done && lane_st[1].div_done &&
	                 lane_st[2].div_done && lane_st[3].div_done;

	// Control sequence of one inversion.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= T_IDLE;
			start_q     <= 1'b0;
			merge_go_q  <= 1'b0;
			div_go_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_row_q   <= '0;
		end else begin
			start_q    <= 1'b0;
			merge_go_q <= 1'b0;
			div_go_q   <= 1'b0;
			case (st_q)
				T_IDLE: begin
					if (in_acc && (row_number == LAST_ROW)) begin
						st_q    <= T_COMP;
						start_q <= 1'b1;
					end
				end
				T_COMP: begin
					if (all_cof) begin
						st_q       <= T_MERGE;
						merge_go_q <= 1'b1;
					end
				end
				T_MERGE: begin
					if (det_v) begin
						st_q     <= T_DIV;
						div_go_q <= 1'b1;
					end
				end
				T_DIV: begin
					if (all_div) begin
						st_q        <= T_OUT;
						out_valid_q <= 1'b1;
						out_row_q   <= '0;
					end
				end
				T_OUT: begin
					if (out_ready) begin
						if (out_row_q == LAST_ROW) begin
							st_q        <= T_IDLE;
							out_valid_q <= 1'b0;
						end else begin
							out_row_q <= out_row_q + 2'd1;
						end
					end
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	// Determinant held for the dividers and the singular flag.
	always_ff @(posedge clk) begin
		if ((st_q == T_MERGE) && det_v) begin
			det_q <= det_m;
		end
	end

	// Result row selection.
	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign singular  = det_q.zero;
	assign last_row  = (out_row_q == LAST_ROW);
	assign inv_col0  = det_q.zero ? 32'sd0 : lane_inv[out_row_q][0];
	assign inv_col1  = det_q.zero ? 32'sd0 : lane_inv[out_row_q][1];
	assign inv_col2  = det_q.zero ? 32'sd0 : lane_inv[out_row_q][2];
	assign inv_col3  = det_q.zero ? 32'sd0 : lane_inv[out_row_q][3];

endmodule

`default_nettype wire

### hw/rtl/m4inv_chk.sv
// Port-level checker for the matrix inverse top level, bound to it below.
// Depends only on the port list of matrix4x4_inverse_top.
`timescale 1ns / 1ps
`default_nettype none

module m4inv_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  row_number,
	input wire logic [31:0] elem_col0,
	input wire logic [31:0] elem_col1,
	input wire logic [31:0] elem_col2,
	input wire logic [31:0] elem_col3,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  out_row,
	input wire logic [31:0] inv_col0,
	input wire logic [31:0] inv_col1,
	input wire logic [31:0] inv_col2,
	input wire logic [31:0] inv_col3,
	input wire logic        singular,
	input wire logic        last_row
);

	// A stalled result keeps its row.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_row))
		else $error("result row changed while stalled");

	// Result rows follow one another without a gap.
	a_row_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_row |=> out_valid && (out_row == $past(out_row) + 2'd1))
		else $error("result rows out of sequence");

	// A singular matrix gives all-zero rows.
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> (inv_col0 == 32'd0) && (inv_col1 == 32'd0) &&
		(inv_col2 == 32'd0) && (inv_col3 == 32'd0))
		else $error("singular result with nonzero elements");

	// Taking row 3 starts an inversion and drops in_ready and out_valid.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (row_number == 2'd3) |=> !in_ready && !out_valid)
		else $error("request taken while inverting");

endmodule

bind matrix4x4_inverse_top m4inv_chk u_chk (.*);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the 4x4 fixed-point matrix inverse block.
// Depends on m4inv_pkg and matrix4x4_inverse_top; drives rows, checks each inverse row.
`timescale 1ns / 1ps

module testbench;
	import m4inv_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [1:0]         row;
		logic signed [31:0] col [4];
		logic               sing;
		logic               last;
	} inv_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] row_number = '0;
	logic signed [31:0] elem_col0 = '0, elem_col1 = '0, elem_col2 = '0, elem_col3 = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] out_row;
	logic signed [31:0] inv_col0, inv_col1, inv_col2, inv_col3;
	logic singular, last_row;

	matrix4x4_inverse_top u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.row_number(row_number), .elem_col0(elem_col0), .elem_col1(elem_col1),
		.elem_col2(elem_col2), .elem_col3(elem_col3), .out_valid(out_valid),
		.out_ready(out_ready), .out_row(out_row), .inv_col0(inv_col0),
		.inv_col1(inv_col1), .inv_col2(inv_col2), .inv_col3(inv_col3),
		.singular(singular), .last_row(last_row)
	);

	always #1 clk = ~clk;

	// Predictor state: the shadow copy of the stored matrix.
	logic signed [31:0] mat_shadow [16];
	inv_row_t expected_rows [$];
	int errors = 0;
	int rows_sent = 0;
	int rows_seen = 0;
	int singular_seen = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	longint cycles = 0;

	// Signed 3x3 determinant of the matrix without row r and column c.
	function automatic logic signed [127:0] minor3(int r, int c);
		int rs [3];
		int cs [3];
		int n;
		logic signed [127:0] a [3][3];
		n = 0;
		for (int k = 0; k < 4; k++) if (k != r) begin rs[n] = k; n++; end
		n = 0;
		for (int k = 0; k < 4; k++) if (k != c) begin cs[n] = k; n++; end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				a[i][j] = mat_shadow[rs[i] * 4 + cs[j]];
		return a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
			- a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
			+ a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
	endfunction

	// Rounded (halves away from zero), saturated num * 2^(2F) / den.
	function automatic logic signed [31:0] scaled_quotient(logic signed [191:0] num,
			logic signed [191:0] den);
		logic [191:0] nm, dm, q;
		logic neg;
		neg = (num < 0) != (den < 0);
		nm = (num < 0) ? -num : num;
		dm = (den < 0) ? -den : den;
		q = ((nm << (2 * FB + 1)) + dm) / (dm << 1);
		if (neg) return (q >= 192'h8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]);
		return (q > 192'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
	endfunction

	// Store one row in the shadow matrix; for row 3 queue the four inverse rows.
	task automatic predict_inverse(logic [1:0] r, logic signed [31:0] e [4]);
		logic signed [191:0] cof [4][4];
		logic signed [191:0] det;
		inv_row_t o;
		for (int c = 0; c < 4; c++) mat_shadow[r * 4 + c] = e[c];
		if (r != LAST_ROW) return;
		det = 0;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				cof[i][j] = minor3(i, j);
				if ((i + j) % 2) cof[i][j] = -cof[i][j];
			end
		for (int j = 0; j < 4; j++) det += $signed(mat_shadow[j]) * cof[0][j];
		for (int i = 0; i < 4; i++) begin
			o.row = i[1:0];
			for (int j = 0; j < 4; j++)
				o.col[j] = (det == 0) ? 32'sd0 : scaled_quotient(cof[j][i], det);
			o.sing = (det == 0);
			o.last = (i == 3);
			expected_rows = {expected_rows, o};
		end
	endtask

	// Send one row request and feed the predictor on acceptance.
	task automatic send_row(logic [1:0] r, logic signed [31:0] e [4]);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		row_number <= r;
		elem_col0 <= e[0];
		elem_col1 <= e[1];
		elem_col2 <= e[2];
		elem_col3 <= e[3];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_inverse(r, e);
		rows_sent++;
		@(negedge clk);
	endtask

	// Receiver readiness changes at the falling edge.
	always @(negedge clk) begin
		out_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
	end

	// Result checking at the rising edge.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && out_ready) begin
			inv_row_t x;
			logic signed [31:0] got [4];
			got = '{inv_col0, inv_col1, inv_col2, inv_col3};
			rows_seen++;
			if (singular) singular_seen++;
			if (expected_rows.size() == 0) begin
				$error("unexpected result row %0d", out_row);
				errors++;
			end else begin
				x = expected_rows.pop_front();
				if (out_row !== x.row) begin
					$error("out_row: expected %0d, got %0d", x.row, out_row);
					errors++;
				end
				for (int j = 0; j < 4; j++)
					if (got[j] !== x.col[j]) begin
						$error("inv_col%0d: expected %0d, got %0d", j, x.col[j], got[j]);
						errors++;
					end
				if (singular !== x.sing) begin
					$error("singular: expected %0d, got %0d", x.sing, singular);
					errors++;
				end
				if (last_row !== x.last) begin
					$error("last_row: expected %0d, got %0d", x.last, last_row);
					errors++;
				end
			end
		end
	end

	// Watchdog against a hung block.
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Directed stimulus: each group of four rows is one matrix.
	localparam int NDIR = 24;
	logic signed [31:0] dir_rows [NDIR][4] = '{
		// identity
		'{32'sh10000, 0, 0, 0}, '{0, 32'sh10000, 0, 0}, '{0, 0, 32'sh10000, 0},
		'{0, 0, 0, 32'sh10000},
		// all zero: singular
		'{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0},
		// most negative diagonal
		'{32'sh8000_0000, 0, 0, 0}, '{0, 32'sh8000_0000, 0, 0},
		'{0, 0, 32'sh8000_0000, 0}, '{0, 0, 0, 32'sh8000_0000},
		// tiny determinant saturates
		'{1, 0, 0, 0}, '{0, 1, 0, 0}, '{0, 0, 1, 0}, '{0, 0, 0, -1},
		// extremes mixed
		'{32'sh7FFF_FFFF, 32'sh8000_0000, -1, 1}, '{-1, 32'sh7FFF_FFFF, 1, 32'sh8000_0000},
		'{1, -1, 32'sh7FFF_FFFF, 0}, '{32'sh8000_0000, 0, 1, 32'sh7FFF_FFFF},
		// repeated rows: singular
		'{1, 2, 3, 4}, '{1, 2, 3, 4}, '{5, 6, 7, 8}, '{9, 1, 2, 3}
	};

	// Inverse rows known by inspection for the first four directed matrices.
	localparam int NTYPED = 4;
	logic signed [31:0] typed_inv [4 * NTYPED][4] = '{
		// identity inverts to itself
		'{32'sh10000, 0, 0, 0}, '{0, 32'sh10000, 0, 0}, '{0, 0, 32'sh10000, 0},
		'{0, 0, 0, 32'sh10000},
		// singular: zero rows
		'{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0},
		// -32768.0 on the diagonal inverts to -2^-15
		'{-2, 0, 0, 0}, '{0, -2, 0, 0}, '{0, 0, -2, 0}, '{0, 0, 0, -2},
		// the smallest step on the diagonal saturates
		'{32'sh7FFF_FFFF, 0, 0, 0}, '{0, 32'sh7FFF_FFFF, 0, 0},
		'{0, 0, 32'sh7FFF_FFFF, 0}, '{0, 0, 0, 32'sh8000_0000}
	};
	logic typed_sing [NTYPED] = '{1'b0, 1'b1, 1'b0, 1'b0};

	// Check the predicted rows of directed matrix m against its known inverse and put that in their place.
	task automatic apply_typed(int m);
		int base;
		base = expected_rows.size() - 4;
		for (int k = 0; k < 4; k++) begin
			for (int j = 0; j < 4; j++) begin
				if (expected_rows[base + k].col[j] !== typed_inv[m * 4 + k][j]) begin
					$error("typed inv_col%0d: expected %0d, predictor %0d", j,
						typed_inv[m * 4 + k][j], expected_rows[base + k].col[j]);
					errors++;
				end
				expected_rows[base + k].col[j] = typed_inv[m * 4 + k][j];
			end
			expected_rows[base + k].sing = typed_sing[m];
		end
	endtask

	// Random element: mostly moderate Q16.16, sometimes full range.
	function automatic logic signed [31:0] rand_elem();
		case ($urandom_range(9))
			0: return $urandom;
			1: return $urandom_range(3) == 0 ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			2: return 0;
			default: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
		endcase
	endfunction

	task automatic random_matrix();
		logic signed [31:0] e [4];
		int perm [3];
		perm = '{0, 1, 2};
		perm.shuffle();
		// Occasionally rewrite a row twice or singularize by duplication.
		for (int k = 0; k < 3; k++) begin
			for (int c = 0; c < 4; c++) e[c] = rand_elem();
			send_row(perm[k][1:0], e);
			if ($urandom_range(9) == 0) begin
				for (int c = 0; c < 4; c++) e[c] = rand_elem();
				send_row(perm[k][1:0], e);
			end
		end
		if ($urandom_range(7) == 0)
			for (int c = 0; c < 4; c++) e[c] = mat_shadow[c];
		else
			for (int c = 0; c < 4; c++) e[c] = rand_elem();
		send_row(LAST_ROW, e);
	endtask

	initial begin
		logic signed [31:0] e [4];
		for (int i = 0; i < 16; i++) mat_shadow[i] = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < NDIR; i++) begin
			e = dir_rows[i];
			send_row(i[1:0], e);
			// The first matrices are checked against their known inverse.
			if (i[1:0] == LAST_ROW && i < 4 * NTYPED) apply_typed(i / 4);
		end

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 61 : 0;
			recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 30 : 0;
			while (rows_sent < NDIR + (phase + 1) * 130) random_matrix();
		end
		in_valid <= 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;

		while (expected_rows.size() > 0) @(posedge clk);
		repeat (400) @(posedge clk);
		$display("Sent %0d row requests; checked %0d inverse rows, %0d singular.",
			rows_sent, rows_seen, singular_seen);
		if (errors == 0 && expected_rows.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### matrix4x4_inverse_top.f
hw/rtl/m4inv_pkg.sv
hw/rtl/m4inv_ram.sv
hw/rtl/m4inv_lane.sv
hw/rtl/m4inv_merge.sv
hw/rtl/matrix4x4_inverse_top.sv
hw/rtl/m4inv_chk.sv
tb/testbench.sv
